>>> src/pbwt_prefix_divergence_update_defines.svh
// ----------------------------------------------------------------------------
// pbwt defines
// assertion macros shared by the pbwt prefix and divergence update block
// ----------------------------------------------------------------------------
`ifndef PBWT_PREFIX_DIVERGENCE_UPDATE_DEFINES_SVH
`define PBWT_PREFIX_DIVERGENCE_UPDATE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PBWT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pbwt check failed");

// next-cycle implication, checked outside reset
`define PBWT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pbwt check failed");

`endif

>>> src/pbwt_pkg.sv
// ----------------------------------------------------------------------------
// pbwt package
// sizes, action codes and control types of the pbwt prefix and divergence update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbwt_pkg;

    localparam int HAPLOTYPES = 1024;
    localparam int SITE_BITS  = 20;

    localparam int ID_W  = $clog2(HAPLOTYPES);
    localparam int CNT_W = $clog2(HAPLOTYPES + 1);

    localparam logic [CNT_W-1:0]     HAP_CNT  = CNT_W'(HAPLOTYPES);
    localparam logic [ID_W-1:0]      LAST_POS = ID_W'(HAPLOTYPES - 1);
    localparam logic [SITE_BITS-1:0] SITE_MAX = {SITE_BITS{1'b1}};

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_ADVANCE = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;

    typedef struct packed {
        logic                 start;
        logic                 step;
        logic                 one;
        logic [SITE_BITS-1:0] start_div;
        logic [SITE_BITS-1:0] dv;
    } t_part_ctl;

    typedef struct packed {
        logic [CNT_W-1:0]     nz;
        logic [CNT_W-1:0]     no;
        logic [SITE_BITS-1:0] wdiv;
    } t_part_stat;

endpackage

>>> src/pbwt_ram.sv
// ----------------------------------------------------------------------------
// pbwt ram
// generic simple dual-port memory, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pbwt_part_unit.sv
// ----------------------------------------------------------------------------
// pbwt partition unit
// running divergence maxima and group counters, one haplotype per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbwt_part_unit
    import pbwt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_part_ctl  i_ctl,
    output t_part_stat o_stat
);

    logic [SITE_BITS-1:0] r_zmax;
    logic [SITE_BITS-1:0] r_omax;
    logic [CNT_W-1:0]     r_nz;
    logic [CNT_W-1:0]     r_no;
    logic [SITE_BITS-1:0] n_zmax;
    logic [SITE_BITS-1:0] n_omax;

    always_comb begin
        n_zmax = (i_ctl.dv > r_zmax) ? i_ctl.dv : r_zmax;
        n_omax = (i_ctl.dv > r_omax) ? i_ctl.dv : r_omax;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zmax <= '0;
            r_omax <= '0;
            r_nz   <= '0;
            r_no   <= '0;
        end else if (i_ctl.start) begin
            r_zmax <= i_ctl.start_div;
            r_omax <= i_ctl.start_div;
            r_nz   <= '0;
            r_no   <= '0;
        end else if (i_ctl.step) begin
            // the group that takes the haplotype restarts its maximum at zero
            if (i_ctl.one) begin
                r_zmax <= n_zmax;
                r_omax <= '0;
                r_no   <= r_no + CNT_W'(1);
            end else begin
                r_zmax <= '0;
                r_omax <= n_omax;
                r_nz   <= r_nz + CNT_W'(1);
            end
        end
    end

    assign o_stat.nz   = r_nz;
    assign o_stat.no   = r_no;
    assign o_stat.wdiv = i_ctl.one ? n_omax : n_zmax;

endmodule

>>> src/pbwt_prefix_divergence_update.sv
// ----------------------------------------------------------------------------
// pbwt prefix divergence update
// positional prefix order and divergence array kept in memories, split per site
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
// load, unknown action: result registered at accept; read: memories read at accept,
// then result registered in ST_RD; advance: walk through a 3-stage read pipeline,
// then copy of the one-allele group, both paced by one memory port per cycle
// a new item is taken only when idle and the result register is free or taken
// synchronous reset: identity order, zero divergence, zero site count at once
// (order and divergences read as reset values until the first advance ends)

module pbwt_prefix_divergence_update
    import pbwt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  logic [ID_W-1:0]      i_index,
    input  logic                 i_allele,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ID_W-1:0]      o_haplotype_id,
    output logic [SITE_BITS-1:0] o_divergence,
    output logic [SITE_BITS-1:0] o_site_count
);

`include "pbwt_prefix_divergence_update_defines.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_WALK = 3'd2;
    localparam logic [2:0] ST_COPY = 3'd3;

    logic [2:0]           r_state;
    logic                 r_fresh;
    logic [SITE_BITS-1:0] r_sites;
    logic [ID_W-1:0]      r_idx;
    logic                 r_idx_ok;
    logic [CNT_W-1:0]     r_rd_ptr;
    logic                 r_v1;
    logic [ID_W-1:0]      r_pos1;
    logic                 r_v2;
    logic [ID_W-1:0]      r_pos2;
    logic [ID_W-1:0]      r_hid2;
    logic [SITE_BITS-1:0] r_dv2;
    logic [CNT_W-1:0]     r_cp;
    logic                 r_cv;
    logic [ID_W-1:0]      r_cpos;
    logic                 r_out_valid;
    logic [ID_W-1:0]      r_out_id;
    logic [SITE_BITS-1:0] r_out_div;
    logic [SITE_BITS-1:0] r_out_sites;

    logic                 w_accept;
    logic                 w_take;
    logic                 w_out_load;
    logic                 w_in_range;
    logic [SITE_BITS-1:0] w_sites_inc;
    logic [ID_W-1:0]      w_hid1;
    logic [SITE_BITS-1:0] w_dv1;
    logic                 w_one;
    logic                 w_walk_end;
    logic                 w_copy_end;
    logic [CNT_W:0]       w_total;
    logic [CNT_W-1:0]     w_copy_addr;

    logic [ID_W-1:0]      w_po_raddr;
    logic                 w_pd_we;
    logic [ID_W-1:0]      w_pd_waddr;
    logic [ID_W-1:0]      w_po_wdata;
    logic [SITE_BITS-1:0] w_dv_wdata;
    logic [ID_W-1:0]      w_po_rdata;
    logic [SITE_BITS-1:0] w_dv_rdata;
    logic                 w_al_we;
    logic                 w_al_rdata;
    logic                 w_ones_we;
    logic [ID_W-1:0]      w_ones_id_rdata;
    logic [SITE_BITS-1:0] w_ones_div_rdata;

    t_part_ctl  w_ctl;
    t_part_stat w_stat;

    assign w_take     = r_out_valid && !i_stall;
    assign o_stall    = (r_state != ST_IDLE) || (r_out_valid && i_stall);
    assign w_accept   = i_valid && !o_stall;
    assign w_in_range = {1'b0, i_index} < HAP_CNT;
    assign w_sites_inc = (r_sites == SITE_MAX) ? SITE_MAX : r_sites + SITE_BITS'(1);

    // result register is loaded this cycle
    assign w_out_load = (r_state == ST_RD) || ((r_state == ST_COPY) && w_copy_end) ||
                        ((r_state == ST_IDLE) && w_accept && (i_action != ACT_READ) &&
                         (i_action != ACT_ADVANCE));

    // until the first advance ends the order and divergence memories hold nothing valid, use reset values
    assign w_hid1 = r_fresh ? r_pos1 : w_po_rdata;
    assign w_dv1  = r_fresh ? '0 : w_dv_rdata;
    assign w_one  = w_al_rdata;

    assign w_walk_end  = r_v2 && (r_pos2 == LAST_POS);
    assign w_copy_end  = (w_stat.no == '0) || (r_cv && ({1'b0, r_cpos} == w_stat.no - CNT_W'(1)));
    assign w_total     = {1'b0, w_stat.nz} + {1'b0, w_stat.no};
    assign w_copy_addr = w_stat.nz + {1'b0, r_cpos};

    assign w_ctl.start     = w_accept && (i_action == ACT_ADVANCE);
    assign w_ctl.step      = (r_state == ST_WALK) && r_v2;
    assign w_ctl.one       = w_one;
    assign w_ctl.start_div = w_sites_inc;
    assign w_ctl.dv        = r_dv2;

    assign w_po_raddr = (r_state == ST_WALK) ? r_rd_ptr[ID_W-1:0] : i_index;
    assign w_al_we    = w_accept && (i_action == ACT_LOAD) && w_in_range;
    assign w_ones_we  = w_ctl.step && w_one;

    always_comb begin
        if (r_state == ST_COPY) begin
            w_pd_we    = r_cv;
            w_pd_waddr = w_copy_addr[ID_W-1:0];
            w_po_wdata = w_ones_id_rdata;
            w_dv_wdata = w_ones_div_rdata;
        end else begin
            w_pd_we    = w_ctl.step && !w_one;
            w_pd_waddr = w_stat.nz[ID_W-1:0];
            w_po_wdata = r_hid2;
            w_dv_wdata = w_stat.wdiv;
        end
    end

    pbwt_ram #(.WIDTH(ID_W), .DEPTH(HAPLOTYPES)) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (w_pd_we),
        .i_waddr (w_pd_waddr),
        .i_wdata (w_po_wdata),
        .i_raddr (w_po_raddr),
        .o_rdata (w_po_rdata)
    );

    pbwt_ram #(.WIDTH(SITE_BITS), .DEPTH(HAPLOTYPES)) u_div_ram (
        .i_clk   (i_clk),
        .i_we    (w_pd_we),
        .i_waddr (w_pd_waddr),
        .i_wdata (w_dv_wdata),
        .i_raddr (w_po_raddr),
        .o_rdata (w_dv_rdata)
    );

    pbwt_ram #(.WIDTH(1), .DEPTH(HAPLOTYPES)) u_allele_ram (
        .i_clk   (i_clk),
        .i_we    (w_al_we),
        .i_waddr (i_index),
        .i_wdata (i_allele),
        .i_raddr (w_hid1),
        .o_rdata (w_al_rdata)
    );

    pbwt_ram #(.WIDTH(ID_W), .DEPTH(HAPLOTYPES)) u_ones_id_ram (
        .i_clk   (i_clk),
        .i_we    (w_ones_we),
        .i_waddr (w_stat.no[ID_W-1:0]),
        .i_wdata (r_hid2),
        .i_raddr (r_cp[ID_W-1:0]),
        .o_rdata (w_ones_id_rdata)
    );

    pbwt_ram #(.WIDTH(SITE_BITS), .DEPTH(HAPLOTYPES)) u_ones_div_ram (
        .i_clk   (i_clk),
        .i_we    (w_ones_we),
        .i_waddr (w_stat.no[ID_W-1:0]),
        .i_wdata (w_stat.wdiv),
        .i_raddr (r_cp[ID_W-1:0]),
        .o_rdata (w_ones_div_rdata)
    );

    pbwt_part_unit u_part (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fresh     <= 1'b1;
            r_sites     <= '0;
            r_out_valid <= 1'b0;
            r_rd_ptr    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_cp        <= '0;
            r_cv        <= 1'b0;
            r_idx_ok    <= 1'b0;
        end else begin
            if (w_take && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_idx    <= i_index;
                        r_idx_ok <= w_in_range;
                        if (i_action == ACT_READ) begin
                            r_state <= ST_RD;
                        end else if (i_action == ACT_ADVANCE) begin
                            r_state  <= ST_WALK;
                            r_rd_ptr <= '0;
                            r_v1     <= 1'b0;
                            r_v2     <= 1'b0;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_id    <= '0;
                            r_out_div   <= '0;
                            r_out_sites <= r_sites;
                        end
                    end
                end
                ST_RD: begin
                    r_out_valid <= 1'b1;
                    r_out_id    <= r_idx_ok ? (r_fresh ? r_idx : w_po_rdata) : '0;
                    r_out_div   <= (r_idx_ok && !r_fresh) ? w_dv_rdata : '0;
                    r_out_sites <= r_sites;
                    r_state     <= ST_IDLE;
                end
                ST_WALK: begin
                    // stage 1 issues the order read, stage 2 the allele read
                    if (r_rd_ptr != HAP_CNT) begin
                        r_rd_ptr <= r_rd_ptr + CNT_W'(1);
                        r_v1     <= 1'b1;
                        r_pos1   <= r_rd_ptr[ID_W-1:0];
                    end else begin
                        r_v1 <= 1'b0;
                    end
                    r_v2   <= r_v1;
                    r_pos2 <= r_pos1;
                    r_hid2 <= w_hid1;
                    r_dv2  <= w_dv1;
                    // pipeline is already empty behind the last haplotype
                    if (w_walk_end) begin
                        r_state <= ST_COPY;
                        r_cp    <= '0;
                        r_cv    <= 1'b0;
                    end
                end
                ST_COPY: begin
                    // one-allele group goes behind the zero-allele group
                    if (r_cp != w_stat.no) begin
                        r_cp   <= r_cp + CNT_W'(1);
                        r_cv   <= 1'b1;
                        r_cpos <= r_cp[ID_W-1:0];
                    end else begin
                        r_cv <= 1'b0;
                    end
                    if (w_copy_end) begin
                        r_fresh     <= 1'b0;
                        r_sites     <= w_sites_inc;
                        r_out_valid <= 1'b1;
                        r_out_id    <= '0;
                        r_out_div   <= '0;
                        r_out_sites <= w_sites_inc;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_haplotype_id = r_out_id;
    assign o_divergence   = r_out_div;
    assign o_site_count   = r_out_sites;

    `PBWT_ASSERT_NEXT(a_load_result, w_accept && (i_action == ACT_LOAD), o_valid)
    `PBWT_ASSERT_NEXT(a_walk_total, w_walk_end, w_total == {1'b0, HAP_CNT})
    `PBWT_ASSERT_NEXT(a_site_hold, (r_state != ST_COPY) || !w_copy_end, $stable(r_sites))
    `PBWT_ASSERT_IMPL(a_busy_stall, r_state != ST_IDLE, o_stall)

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbwt prefix divergence update testbench
// drives load, advance, read and unknown actions through the valid/stall
// handshake and checks every result against a positional prefix order and
// divergence tracker kept in a scoreboard, under several idling mixes
// ----------------------------------------------------------------------------

module tb_top
    import pbwt_pkg::*;
();

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 580;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int EXP_DEPTH    = 16;

    typedef struct packed {
        logic [ID_W-1:0]      hap_id;
        logic [SITE_BITS-1:0] div;
        logic [SITE_BITS-1:0] sites;
    } t_entry;

    class pbwt_scoreboard;
        logic [ID_W-1:0]      order_mem [HAPLOTYPES];
        logic [SITE_BITS-1:0] div_mem [HAPLOTYPES];
        logic                 allele_mem [HAPLOTYPES];
        logic [SITE_BITS-1:0] sites_done;
        t_entry               exp_fifo [EXP_DEPTH];
        logic [3:0]           exp_wr;
        logic [3:0]           exp_rd;
        int                   exp_count;
        int                   failures;

        function new();
            for (int i = 0; i < HAPLOTYPES; i++) begin
                order_mem[i]  = ID_W'(i);
                div_mem[i]    = '0;
                allele_mem[i] = 1'b0;
            end
            sites_done = '0;
            exp_wr     = '0;
            exp_rd     = '0;
            exp_count  = 0;
            failures   = 0;
        endfunction

        // stable split of the sorted order into zero then one allele groups
        function void split_site();
            logic [ID_W-1:0]      ones_id [HAPLOTYPES];
            logic [SITE_BITS-1:0] ones_div [HAPLOTYPES];
            logic [SITE_BITS-1:0] zmax;
            logic [SITE_BITS-1:0] omax;
            logic [SITE_BITS-1:0] dv;
            logic [ID_W-1:0]      hid;
            int                   nz;
            int                   no;
            zmax = (sites_done != SITE_MAX) ? sites_done + 1'b1 : SITE_MAX;
            omax = zmax;
            nz   = 0;
            no   = 0;
            for (int p = 0; p < HAPLOTYPES; p++) begin
                hid = order_mem[p];
                dv  = div_mem[p];
                if (dv > zmax) zmax = dv;
                if (dv > omax) omax = dv;
                if (!allele_mem[hid]) begin
                    // nz never passes p, so this slot was already read
                    order_mem[nz] = hid;
                    div_mem[nz]   = zmax;
                    nz++;
                    zmax = '0;
                end else begin
                    ones_id[no]  = hid;
                    ones_div[no] = omax;
                    no++;
                    omax = '0;
                end
            end
            for (int k = 0; k < no; k++) begin
                order_mem[nz + k] = ones_id[k];
                div_mem[nz + k]   = ones_div[k];
            end
            if (sites_done != SITE_MAX) sites_done++;
        endfunction

        function void take_item(logic [1:0] act, logic [ID_W-1:0] idx, logic al);
            t_entry e;
            e = '0;
            unique case (act)
                ACT_LOAD: begin
                    allele_mem[idx] = al;
                end
                ACT_ADVANCE: begin
                    split_site();
                end
                ACT_READ: begin
                    e.hap_id = order_mem[idx];
                    e.div    = div_mem[idx];
                end
                default: begin
                end
            endcase
            e.sites          = sites_done;
            exp_fifo[exp_wr] = e;
            exp_wr++;
            exp_count++;
        endfunction

        function void check_entry(logic [ID_W-1:0] hap_id, logic [SITE_BITS-1:0] div,
                                  logic [SITE_BITS-1:0] sites);
            t_entry e;
            if (exp_count == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: id %0d div %0d sites %0d",
                             hap_id, div, sites);
                return;
            end
            e = exp_fifo[exp_rd];
            exp_rd++;
            exp_count--;
            if (hap_id !== e.hap_id || div !== e.div || sites !== e.sites) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: expected id %0d div %0d sites %0d, %s %0d %0d %0d",
                             e.hap_id, e.div, e.sites, "got id div sites",
                             hap_id, div, sites);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_action;
    logic [ID_W-1:0]      i_index;
    logic                 i_allele;
    logic                 o_valid;
    logic                 i_stall;
    logic [ID_W-1:0]      o_haplotype_id;
    logic [SITE_BITS-1:0] o_divergence;
    logic [SITE_BITS-1:0] o_site_count;

    pbwt_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_cycles;
    int             cycle_count = 0;

    pbwt_prefix_divergence_update dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_index        (i_index),
        .i_allele       (i_allele),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_haplotype_id (o_haplotype_id),
        .o_divergence   (o_divergence),
        .o_site_count   (o_site_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_entry(o_haplotype_id, o_divergence, o_site_count);
    end

    task automatic drive_item(input logic [1:0] act, input logic [ID_W-1:0] idx,
                              input logic al);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_index  <= idx;
        i_allele <= al;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_item(act, idx, al);
        @(negedge i_clk);
    endtask

    task automatic drive_random_item();
        int              roll;
        logic [ID_W-1:0] idx;
        roll = $urandom_range(99);
        idx  = ID_W'($urandom_range(HAPLOTYPES - 1));
        if ($urandom_range(15) == 0) idx = roll[0] ? LAST_POS : '0;
        if (roll < 62)
            drive_item(ACT_LOAD, idx, 1'($urandom_range(1)));
        else if (roll < 88)
            drive_item(ACT_READ, idx, 1'($urandom_range(1)));
        else if (roll < 94)
            drive_item(ACT_ADVANCE, idx, 1'($urandom_range(1)));
        else
            drive_item(ACT_UNKNOWN, idx, 1'($urandom_range(1)));
    endtask

    initial begin
        sb             = new();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = ACT_LOAD;
        i_index        = '0;
        i_allele       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset order and divergences, unknown action
        drive_item(ACT_READ, '0, 1'b0);
        drive_item(ACT_READ, LAST_POS, 1'b1);
        drive_item(ACT_UNKNOWN, LAST_POS, 1'b1);
        drive_item(ACT_LOAD, '0, 1'b1);
        drive_item(ACT_LOAD, LAST_POS, 1'b0);
        // the whole column has to be written before the first advance
        for (int h = 1; h < HAPLOTYPES - 1; h++)
            drive_item(ACT_LOAD, ID_W'(h), 1'($urandom_range(1)));
        drive_item(ACT_ADVANCE, '0, 1'b0);
        drive_item(ACT_READ, '0, 1'b0);
        drive_item(ACT_READ, LAST_POS, 1'b0);
        drive_item(ACT_READ, ID_W'($urandom_range(HAPLOTYPES - 1)), 1'b1);
        drive_item(ACT_LOAD, LAST_POS, 1'b1);
        drive_item(ACT_LOAD, '0, 1'b0);
        drive_item(ACT_ADVANCE, LAST_POS, 1'b1);
        drive_item(ACT_READ, '0, 1'b1);
        drive_item(ACT_READ, LAST_POS, 1'b1);
        drive_item(ACT_READ, ID_W'(HAPLOTYPES / 2 - 1), 1'b0);
        drive_item(ACT_READ, ID_W'(HAPLOTYPES / 2), 1'b0);
        drive_item(ACT_UNKNOWN, '0, 1'b0);
        // back to back advances
        drive_item(ACT_ADVANCE, '0, 1'b0);
        drive_item(ACT_ADVANCE, '0, 1'b0);
        drive_item(ACT_READ, '0, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // long hold-off so the block backs up into its input
                    hold_cycles    = HOLD_CYCLES;
                end
                1: begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                end
                default: begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            repeat (RANDOM_ITEMS / 4) drive_random_item();
        end
        i_valid <= 1'b0;

        while (sb.exp_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
